// ===== rtl/pwmpf_pkg.sv =====
// Shared types, constants and the pin routing table of the PWM period and prescaler fit block.
package pwmpf_pkg;

  localparam int PIN_ENTRIES = 22;
  localparam int QUO_W       = 17;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  localparam logic [2:0] APB2_FIRST_TIMER = 3'd3;

  localparam logic REG_APB1 = 1'b0;
  localparam logic REG_APB2 = 1'b1;

  typedef struct packed {
    logic [7:0] pin;
    logic [2:0] timer;
    logic [2:0] channel;
  } route_t;

  localparam route_t ROUTE_TABLE [PIN_ENTRIES] = '{
    '{8'd5,  3'd0, 3'd1}, '{8'd1,  3'd0, 3'd2}, '{8'd2,  3'd3, 3'd1}, '{8'd3,  3'd3, 3'd2},
    '{8'd6,  3'd1, 3'd1}, '{8'd7,  3'd1, 3'd2}, '{8'd11, 3'd2, 3'd1}, '{8'd12, 3'd2, 3'd2},
    '{8'd16, 3'd1, 3'd3}, '{8'd17, 3'd1, 3'd4}, '{8'd20, 3'd4, 3'd1}, '{8'd21, 3'd5, 3'd1},
    '{8'd22, 3'd2, 3'd1}, '{8'd23, 3'd2, 3'd2}, '{8'd24, 3'd2, 3'd3}, '{8'd25, 3'd2, 3'd4},
    '{8'd30, 3'd3, 3'd1}, '{8'd31, 3'd3, 3'd2}, '{8'd38, 3'd1, 3'd1}, '{8'd39, 3'd1, 3'd2},
    '{8'd40, 3'd1, 3'd3}, '{8'd41, 3'd1, 3'd4}
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROUTE,
    OP_MUL,
    OP_SCALE,
    OP_DOUBLE,
    OP_HALVE,
    OP_CACHE_WR,
    OP_DIV_SET,
    OP_DIV_STEP
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
    logic   out_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic bad_req;
    logic left_go;
    logic right_go;
    logic reach;
    logic hit;
    logic sat;
    logic div_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] apb1;
    logic [31:0] apb2;
  } clocks_t;

endpackage

// ===== rtl/pwmpf_regs.sv =====
// APB register file holding the two timer bus clock rates.
module pwmpf_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pwmpf_pkg::ADDR_W-1:0]  paddr,
  input  logic [pwmpf_pkg::DATA_W-1:0]  pwdata,
  output logic [pwmpf_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output pwmpf_pkg::clocks_t            clocks_o
);
  import pwmpf_pkg::*;

  logic [31:0] apb1_q;
  logic [31:0] apb2_q;
  logic        wr_en;
  logic        sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apb1_q <= 32'd170000000;
      apb2_q <= 32'd170000000;
    end else if (wr_en) begin
      if (sel == REG_APB1) begin
        apb1_q <= pwdata;
      end else begin
        apb2_q <= pwdata;
      end
    end
  end

  assign prdata        = (sel == REG_APB2) ? apb2_q : apb1_q;
  assign clocks_o.apb1 = apb1_q;
  assign clocks_o.apb2 = apb2_q;

endmodule

// ===== rtl/pwmpf_ctrl.sv =====
// Sequencer for route check, period fit loops, cache test and prescaler division.
module pwmpf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output pwmpf_pkg::dp_cmd_t    cmd_o,
  input  pwmpf_pkg::dp_status_t status_i
);
  import pwmpf_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_CHECK    = 15'h0002,
    S_PMUL     = 15'h0004,
    S_LMUL     = 15'h0008,
    S_LSCALE   = 15'h0010,
    S_LTEST    = 15'h0020,
    S_RMUL     = 15'h0040,
    S_RTEST    = 15'h0080,
    S_FSCALE   = 15'h0100,
    S_FTEST    = 15'h0200,
    S_CACHE    = 15'h0400,
    S_DIVSET   = 15'h0800,
    S_DIV      = 15'h1000,
    S_DONE_OK  = 15'h2000,
    S_DONE_REJ = 15'h4000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    cmd_o.out_ok   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.op = OP_ROUTE;
        if (status_i.bad_req) begin
          state_d = S_DONE_REJ;
        end else if (status_i.mode) begin
          state_d = S_LMUL;
        end else begin
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_CACHE;
      end
      S_LMUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_LSCALE;
      end
      S_LSCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = S_LTEST;
      end
      S_LTEST: begin
        if (status_i.left_go) begin
          cmd_o.op = OP_DOUBLE;
          state_d  = S_LMUL;
        end else begin
          state_d = S_RMUL;
        end
      end
      S_RMUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_RTEST;
      end
      S_RTEST: begin
        if (status_i.right_go) begin
          cmd_o.op = OP_HALVE;
          state_d  = S_RMUL;
        end else begin
          state_d = S_FSCALE;
        end
      end
      S_FSCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = S_FTEST;
      end
      S_FTEST: begin
        state_d = status_i.reach ? S_CACHE : S_DONE_REJ;
      end
      S_CACHE: begin
        if (status_i.hit) begin
          state_d = S_DONE_OK;
        end else begin
          cmd_o.op = OP_CACHE_WR;
          state_d  = S_DIVSET;
        end
      end
      S_DIVSET: begin
        cmd_o.op = OP_DIV_SET;
        state_d  = status_i.sat ? S_DONE_OK : S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = S_DONE_OK;
        end
      end
      S_DONE_OK: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DONE_REJ: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pwmpf_dp.sv =====
// Datapath: pin routing, shared multiplier, fit tests, timer cache, divider, output register.
module pwmpf_dp #(
  parameter int NUM_TIMERS  = 6,
  parameter int MAX_PERIOD  = 65536,
  parameter int MAX_DIVIDER = 65536
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pwmpf_pkg::dp_cmd_t                 cmd_i,
  output pwmpf_pkg::dp_status_t              status_o,
  input  pwmpf_pkg::clocks_t                 clocks_i,
  input  logic [pwmpf_pkg::IN_TDATA_W-1:0]   in_data_i,
  input  logic                               in_mode_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pwmpf_pkg::OUT_TDATA_W-1:0]  out_data_o,
  output logic                               out_ok_o
);
  import pwmpf_pkg::*;

  localparam int         TIW          = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [16:0] HALF_PERIOD_C = 17'(MAX_PERIOD / 2);
  localparam logic [16:0] MAX_DIV_C     = 17'(MAX_DIVIDER);

  logic        mode_q;
  logic [7:0]  pin_q;
  logic [31:0] freq_q;
  logic [31:0] req_q;
  logic [16:0] period_q;
  logic [4:0]  lsh_q;
  logic [4:0]  rsh_q;
  logic [2:0]  tmr_q;
  logic [2:0]  chan_q;
  logic [31:0] clk_q;
  logic [47:0] prod_q;
  logic [48:0] prodmd_q;
  logic        big_q;
  logic        recfg_q;
  logic [47:0] rem_q;
  logic [16:0] nlo_q;
  logic [16:0] quo_q;
  logic        sat_q;
  logic [4:0]  cnt_q;

  logic [31:0] cache_freq_q [NUM_TIMERS];
  logic [16:0] cache_per_q  [NUM_TIMERS];

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_ok_q;

  logic            route_hit;
  logic [2:0]      route_tmr;
  logic [2:0]      route_chan;
  logic [TIW-1:0]  cidx;
  logic [48:0]     mul_full;
  logic [48:0]     md_full;
  logic [47:0]     div_num;
  logic [48:0]     div_trial;
  logic [48:0]     div_diff;
  logic            div_ge;
  logic [16:0]     divider;
  logic [15:0]     psc;
  logic [OUT_TDATA_W-1:0] out_pack;

  // first matching entry whose timer exists wins
  always_comb begin
    route_hit  = 1'b0;
    route_tmr  = 3'd0;
    route_chan = 3'd0;
    for (int i = PIN_ENTRIES - 1; i >= 0; i--) begin
      if (ROUTE_TABLE[i].pin == pin_q && 32'(ROUTE_TABLE[i].timer) < NUM_TIMERS) begin
        route_hit  = 1'b1;
        route_tmr  = ROUTE_TABLE[i].timer;
        route_chan = ROUTE_TABLE[i].channel;
      end
    end
  end

  assign cidx      = TIW'(tmr_q);
  assign mul_full  = {17'b0, freq_q} * {32'b0, period_q};
  assign md_full   = {17'b0, prod_q[31:0]} * {32'b0, MAX_DIV_C};
  assign div_num   = {16'b0, clk_q} + {1'b0, prod_q[47:1]};
  assign div_trial = {rem_q, nlo_q[16]};
  assign div_ge    = (div_trial >= {1'b0, prod_q});
  assign div_diff  = div_trial - {1'b0, prod_q};

  always_comb begin
    if (sat_q || quo_q > MAX_DIV_C) begin
      divider = MAX_DIV_C;
    end else if (quo_q == 17'd0) begin
      divider = 17'd1;
    end else begin
      divider = quo_q;
    end
  end
  assign psc = 16'(divider - 17'd1);

  assign status_o.mode     = mode_q;
  assign status_o.bad_req  = !route_hit || freq_q == 32'd0 || req_q == 32'd0 ||
                             req_q > 32'(MAX_PERIOD);
  assign status_o.left_go  = !big_q && ({17'b0, clk_q} > prodmd_q) &&
                             (period_q <= HALF_PERIOD_C);
  assign status_o.right_go = (prod_q > {16'b0, clk_q}) && (period_q > 17'd1);
  assign status_o.reach    = (prod_q <= {16'b0, clk_q}) &&
                             (big_q || {17'b0, clk_q} <= prodmd_q);
  assign status_o.hit      = (cache_freq_q[cidx] == freq_q) && (cache_per_q[cidx] == period_q);
  assign status_o.sat      = ({17'b0, div_num[47:17]} >= prod_q);
  assign status_o.div_last = (cnt_q == 5'd0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q   <= in_mode_i;
        pin_q    <= in_data_i[7:0];
        freq_q   <= in_data_i[39:8];
        req_q    <= in_data_i[71:40];
        period_q <= in_data_i[56:40];
        lsh_q    <= 5'd0;
        rsh_q    <= 5'd0;
        recfg_q  <= 1'b0;
      end
      OP_ROUTE: begin
        tmr_q  <= route_tmr;
        chan_q <= route_chan;
        clk_q  <= (route_tmr < APB2_FIRST_TIMER) ? clocks_i.apb1 : clocks_i.apb2;
      end
      OP_MUL: begin
        prod_q <= mul_full[47:0];
      end
      OP_SCALE: begin
        prodmd_q <= md_full;
        big_q    <= |prod_q[47:32];
      end
      OP_DOUBLE: begin
        period_q <= {period_q[15:0], 1'b0};
        lsh_q    <= lsh_q + 5'd1;
      end
      OP_HALVE: begin
        period_q <= {1'b0, period_q[16:1]};
        rsh_q    <= rsh_q + 5'd1;
      end
      OP_CACHE_WR: begin
        recfg_q <= 1'b1;
      end
      OP_DIV_SET: begin
        rem_q <= {17'b0, div_num[47:17]};
        nlo_q <= div_num[16:0];
        quo_q <= 17'd0;
        sat_q <= status_o.sat;
        cnt_q <= 5'(QUO_W - 1);
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? div_diff[47:0] : div_trial[47:0];
        nlo_q <= {nlo_q[15:0], 1'b0};
        quo_q <= {quo_q[15:0], div_ge};
        cnt_q <= cnt_q - 5'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        cache_freq_q[t] <= 32'd0;
        cache_per_q[t]  <= 17'd0;
      end
    end else if (cmd_i.op == OP_CACHE_WR) begin
      cache_freq_q[cidx] <= freq_q;
      cache_per_q[cidx]  <= period_q;
    end
  end

  always_comb begin
    if (cmd_i.out_ok) begin
      out_pack = {6'b0, recfg_q, rsh_q, lsh_q, 16'(period_q - 17'd1),
                  recfg_q ? psc : 16'd0, period_q, chan_q, tmr_q};
    end else begin
      out_pack = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= out_pack;
      out_ok_q   <= cmd_i.out_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_ok_o    = out_ok_q;

endmodule

// ===== rtl/pwm_period_prescaler_fit_core.sv =====
// Top level of the PWM period fit and prescaler block.
//
//   channel   direction  accepted when                     payload
//   s_axis    in         s_axis_tvalid & s_axis_tready     tdata pin/frequency/period, tuser mode
//   m_axis    out        m_axis_tvalid & m_axis_tready     tdata timer settings, tuser ok
//   apb       in         psel & penable & pwrite & pready  clock rate registers at 0x0, 0x4
//
// One word at a time: exact mode loads, checks the route, multiplies once and tests the cache.
// Fit mode swaps the single multiply for doubling tries (multiply, scale, test), halving tries
// (multiply, test) and a reach test (scale, test); a rewrite then runs the one-bit divider.
// Reset clears the clock registers to 170 MHz and the per-timer cache to zero.
// The output register frees the input side: a new word is taken while a result waits.
module pwm_period_prescaler_fit_core #(
  parameter int NUM_TIMERS  = 6,
  parameter int MAX_PERIOD  = 65536,
  parameter int MAX_DIVIDER = 65536
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pin [7:0], freq [39:8], requested_period [71:40]
  input  logic [pwmpf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // mode [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // timer_index [2:0], channel [5:3], period [22:6], prescaler [38:23], reload [54:39],
  // doublings [59:55], halvings [64:60], reconfigured [65], zero [71:66]
  output logic [pwmpf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // ok [0]
  output logic                               m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pwmpf_pkg::ADDR_W-1:0]       paddr,
  input  logic [pwmpf_pkg::DATA_W-1:0]       pwdata,
  output logic [pwmpf_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);
  import pwmpf_pkg::*;

  clocks_t    clocks;
  dp_cmd_t    cmd;
  dp_status_t status;

  pwmpf_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .clocks_o (clocks)
  );

  pwmpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  pwmpf_dp #(
    .NUM_TIMERS  (NUM_TIMERS),
    .MAX_PERIOD  (MAX_PERIOD),
    .MAX_DIVIDER (MAX_DIVIDER)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .clocks_i    (clocks),
    .in_data_i   (s_axis_tdata),
    .in_mode_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_ok_o    (m_axis_tuser)
  );

endmodule

// ===== rtl/pwmpf_checker.sv =====
// Port-level checks of the PWM period fit block and their binding.
module pwmpf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [pwmpf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                               m_axis_tuser
);
  import pwmpf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("rejected word carries nonzero fields");

  a_hit_no_psc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && !m_axis_tdata[65] |-> m_axis_tdata[38:23] == 16'd0)
    else $error("prescaler reported without rewrite");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[54:39] == 16'(m_axis_tdata[22:6] - 17'd1) && m_axis_tdata[22:6] != 17'd0)
    else $error("reload does not match period");

  a_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[5:3] != 3'd0 && m_axis_tdata[5:3] <= 3'd4 && m_axis_tdata[2:0] <= 3'd5)
    else $error("accepted word has bad timer or channel");

endmodule

bind pwm_period_prescaler_fit_core pwmpf_checker u_pwmpf_checker (.*);
